// ----- src/mvws_pkg.sv -----
// Shared types and constants for max_values_within_spread.
// No dependencies.
package mvws_pkg;
    localparam int unsigned MAX_ITEMS_DEF = 1024;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 11;
    localparam logic [31:0] SPREAD_RESET = 32'd5;
    localparam logic [0:0] REG_MAX_SPREAD = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_SHIFT,
        ST_SORT_PUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_LO,
        ST_OUT
    } state_t;
endpackage

// ----- src/mvws_ram.sv -----
// Generic single-write, dual-read synchronous RAM with registered reads.
// No dependencies.
module mvws_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- src/max_values_within_spread.sv -----
// Top level of max_values_within_spread: loads a set, insertion-sorts it in
// place in a RAM, then scans it with a two-pointer window for the largest count.
// Depends on mvws_pkg and mvws_ram.
// Load: one value per cycle while no result is waiting in the output
// register. After the last value of n is loaded, the store is sorted and then
// scanned, and the result is held in an output register. rst_n (async, active
// low) empties the store and sets max_spread to 5; RAM contents are not cleared.
module max_values_within_spread
    #(
    parameter int unsigned MAX_ITEMS = mvws_pkg::MAX_ITEMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] best_count, zero filled above
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mvws_pkg::*;

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned RD = (MAX_ITEMS > 1) ? MAX_ITEMS : 2;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] best_reg, best_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] spread_reg;
    logic        oval_reg, oval_next;

    logic          we;
    logic [AW-1:0] waddr, ra, rb;
    logic [31:0]   wdata, rda, rdb;
    logic [CW-1:0] width_c;

    mvws_ram #(.WIDTH(VALUE_W), .DEPTH(RD)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
    );

    assign pready = 1'b1;
    assign prdata = spread_reg;
    assign s_axis_tready = (state_reg == ST_LOAD) && !oval_reg;
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata = 16'(best_reg);
    assign width_c = i_reg - lo_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg <= SPREAD_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_MAX_SPREAD)
        begin
            spread_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        lo_reg   <= lo_next;
        best_reg <= best_next;
        key_reg  <= key_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (s_axis_tvalid && s_axis_tready && s_axis_tlast)
                    state_next = ST_SORT_RD;
            ST_SORT_RD:
                state_next = (i_reg >= count_reg) ? ST_SCAN_RD : ST_SORT_CMP;
            ST_SORT_CMP:
                state_next = ST_SORT_SHIFT;
            ST_SORT_SHIFT:
                state_next = (j_reg != '0 && rdb > key_reg) ? ST_SORT_CMP : ST_SORT_PUT;
            ST_SORT_PUT:
                state_next = ST_SORT_RD;
            ST_SCAN_RD:
                state_next = (i_reg >= count_reg) ? ST_OUT : ST_SCAN_CMP;
            ST_SCAN_CMP:
                state_next = (rda - rdb > spread_reg) ? ST_SCAN_LO : ST_SCAN_RD;
            ST_SCAN_LO:
                state_next = ST_SCAN_CMP;
            ST_OUT:
                state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        best_next  = best_reg;
        key_next   = key_reg;
        oval_next  = oval_reg && !m_axis_tready;
        we         = 1'b0;
        waddr      = j_reg[AW-1:0];
        wdata      = key_reg;
        ra         = i_reg[AW-1:0];
        rb         = lo_reg[AW-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                waddr = count_reg[AW-1:0];
                wdata = s_axis_tdata;
                ra    = '0;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    i_next = CW'(1);
                end
            end
            ST_SORT_RD:
            begin
                // rda <= store[i]; rdb <= store[i-1]
                rb     = AW'(i_reg - CW'(1));
                j_next = i_reg;
                if (i_reg >= count_reg)
                begin
                    i_next    = '0;
                    lo_next   = '0;
                    best_next = '0;
                end
            end
            ST_SORT_CMP:
            begin
                if (j_reg == i_reg)
                    key_next = rda;
                rb = AW'(j_reg - CW'(1));
            end
            ST_SORT_SHIFT:
            begin
                // rdb = store[j-1]
                rb = AW'(j_reg - CW'(2));
                if (j_reg != '0 && rdb > key_reg)
                begin
                    we     = 1'b1;
                    waddr  = j_reg[AW-1:0];
                    wdata  = rdb;
                    j_next = j_reg - CW'(1);
                end
            end
            ST_SORT_PUT:
            begin
                we     = 1'b1;
                i_next = i_reg + CW'(1);
                ra     = AW'(i_reg + CW'(1));
            end
            ST_SCAN_RD:
            begin
                ra = i_reg[AW-1:0];
                rb = lo_reg[AW-1:0];
            end
            ST_SCAN_CMP:
            begin
                if (rda - rdb <= spread_reg)
                begin
                    if (width_c > best_reg)
                        best_next = width_c;
                    i_next = i_reg + CW'(1);
                    ra     = AW'(i_reg + CW'(1));
                end
                else
                begin
                    lo_next = lo_reg + CW'(1);
                    rb      = AW'(lo_reg + CW'(1));
                end
            end
            ST_SCAN_LO:
            begin
                ra = i_reg[AW-1:0];
                rb = lo_reg[AW-1:0];
            end
            ST_OUT:
            begin
                oval_next  = 1'b1;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("loaded count over depth");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> !s_axis_tready)
        else $error("input ready while busy");
    a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(oval_reg) |-> best_reg != '0)
        else $error("empty result");
endmodule
